@@ rtl/u8v_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package u8v_pkg;

  localparam int COUNT_BITS_DEF = 21;
  localparam int BYTE_COUNT_W   = 21;
  localparam int MAX_BYTES_W    = 21;
  localparam int CP_W           = 21;
  localparam int CFG_INDEX_W    = 4;
  localparam int CFG_DATA_W     = 21;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_PERMIT_CONTROLS = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ALLOW_EMPTY     = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_BYTES       = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_ID_MODE         = 4'd3;

  localparam logic [MAX_BYTES_W-1:0] MAX_BYTES_RST = 21'd512;

  // verdict codes
  localparam logic [3:0] ERR_NONE      = 4'd0;
  localparam logic [3:0] ERR_EMPTY     = 4'd1;
  localparam logic [3:0] ERR_TOO_LONG  = 4'd2;
  localparam logic [3:0] ERR_BAD_LEAD  = 4'd3;
  localparam logic [3:0] ERR_BAD_CONT  = 4'd4;
  localparam logic [3:0] ERR_TRUNCATED = 4'd5;
  localparam logic [3:0] ERR_RANGE     = 4'd6;
  localparam logic [3:0] ERR_CONTROL   = 4'd7;
  localparam logic [3:0] ERR_ID_BYTE   = 4'd8;

  localparam logic [CP_W-1:0] CP_MIN_2     = 21'h80;
  localparam logic [CP_W-1:0] CP_MIN_3     = 21'h800;
  localparam logic [CP_W-1:0] CP_MIN_4     = 21'h10000;
  localparam logic [CP_W-1:0] CP_MAX       = 21'h10ffff;
  localparam logic [CP_W-1:0] CP_SURR_LO   = 21'hd800;
  localparam logic [CP_W-1:0] CP_SURR_HI   = 21'hdfff;
  localparam logic [CP_W-1:0] CP_C1_HI     = 21'h9f;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    logic       empty_string;
  } in_t;

  typedef struct packed {
    logic                    is_valid;
    logic [3:0]              error_code;
    logic [BYTE_COUNT_W-1:0] byte_count;
  } out_t;

  // multi-byte sequence decode state
  typedef struct packed {
    logic [1:0]      pending;
    logic [1:0]      seq_len;
    logic [CP_W-1:0] acc;
  } seq_t;

endpackage

`default_nettype wire

@@ rtl/utf8_text_validator.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Strict UTF-8 string checker, one byte per input transfer.
// Input channel (in_valid/in_stall/in_data): one byte per transfer; last_byte
// closes the string, empty_string marks a transfer with no byte (a zero-length
// string when sent with last_byte).
// Output channel (out_valid/out_stall/out_data): one verdict per string, with
// the error code and a saturating byte count.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready; write
// only while no string is in progress.
// Throughput: one byte per cycle while no closing transfer is stalled, set by
// the single decode step between the per-string state registers. The verdict
// is captured in the output register by the closing transfer.
// While a verdict waits under out_stall, bytes that do not close a string are
// still taken; a closing transfer is stalled until the verdict is taken.
// Reset clears the per-string state and the output valid, and loads the
// register defaults (controls rejected, empty allowed, 512 bytes, ID mode off).
module utf8_text_validator #(
  parameter int COUNT_BITS = u8v_pkg::COUNT_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire u8v_pkg::in_t                      in_data,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output u8v_pkg::out_t                          out_data,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [u8v_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [u8v_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int CMP_W = (COUNT_BITS > u8v_pkg::BYTE_COUNT_W) ?
                         COUNT_BITS : u8v_pkg::BYTE_COUNT_W;
  localparam logic [COUNT_BITS-1:0] CNT_TOP = {COUNT_BITS{1'b1}};
  localparam logic [CMP_W-1:0] OUT_TOP = CMP_W'({u8v_pkg::BYTE_COUNT_W{1'b1}});

  logic                              permit_controls_r;
  logic                              allow_empty_r;
  logic [u8v_pkg::MAX_BYTES_W-1:0]   max_bytes_r;
  logic                              id_mode_r;

  u8v_pkg::seq_t                     seq_r, seq_nxt, seq_chk;
  logic [COUNT_BITS-1:0]             bytes_seen_r, bytes_seen_nxt, bytes_inc;
  logic [3:0]                        first_error_r, first_error_nxt;
  logic                              too_long_r, too_long_nxt;
  logic [3:0]                        byte_err;

  logic                              out_valid_r;
  u8v_pkg::out_t                     out_data_r, out_data_nxt;
  logic                              in_xfer, out_xfer, has_byte;
  logic [3:0]                        code;
  logic [CMP_W-1:0]                  count_wide;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r && out_stall && in_data.last_byte;
  assign in_xfer   = in_valid && !in_stall;
  assign out_xfer  = out_valid_r && !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign has_byte  = in_xfer && !in_data.empty_string;

  u8v_byte_check u_check (
    .data_byte       (in_data.data_byte),
    .permit_controls (permit_controls_r),
    .id_mode         (id_mode_r),
    .seq_cur         (seq_r),
    .seq_nxt         (seq_chk),
    .err             (byte_err)
  );

  assign bytes_inc = bytes_seen_r + COUNT_BITS'(1);

  always_comb begin
    seq_nxt         = seq_r;
    bytes_seen_nxt  = bytes_seen_r;
    first_error_nxt = first_error_r;
    too_long_nxt    = too_long_r;
    if (has_byte) begin
      if (bytes_seen_r == CNT_TOP) begin
        too_long_nxt = 1'b1;
      end else begin
        bytes_seen_nxt = bytes_inc;
        if (CMP_W'(bytes_inc) > CMP_W'(max_bytes_r)) too_long_nxt = 1'b1;
      end
      // after the first error the rest of the string is only counted
      if (first_error_r == u8v_pkg::ERR_NONE) begin
        first_error_nxt = byte_err;
        seq_nxt         = seq_chk;
      end
    end
  end

  always_comb begin
    if (bytes_seen_nxt == '0 && !allow_empty_r) begin
      code = u8v_pkg::ERR_EMPTY;
    end else if (too_long_nxt) begin
      code = u8v_pkg::ERR_TOO_LONG;
    end else if (first_error_nxt != u8v_pkg::ERR_NONE) begin
      code = first_error_nxt;
    end else if (seq_nxt.pending != 2'd0) begin
      code = u8v_pkg::ERR_TRUNCATED;
    end else begin
      code = u8v_pkg::ERR_NONE;
    end
  end

  assign count_wide = CMP_W'(bytes_seen_nxt);

  always_comb begin
    out_data_nxt.is_valid   = (code == u8v_pkg::ERR_NONE);
    out_data_nxt.error_code = code;
    out_data_nxt.byte_count = (count_wide > OUT_TOP) ?
                              OUT_TOP[u8v_pkg::BYTE_COUNT_W-1:0] :
                              count_wide[u8v_pkg::BYTE_COUNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      permit_controls_r <= 1'b0;
      allow_empty_r     <= 1'b1;
      max_bytes_r       <= u8v_pkg::MAX_BYTES_RST;
      id_mode_r         <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        u8v_pkg::CFG_PERMIT_CONTROLS: permit_controls_r <= cfg_data[0];
        u8v_pkg::CFG_ALLOW_EMPTY:     allow_empty_r     <= cfg_data[0];
        u8v_pkg::CFG_MAX_BYTES:       max_bytes_r       <= cfg_data;
        u8v_pkg::CFG_ID_MODE:         id_mode_r         <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r         <= '0;
      bytes_seen_r  <= '0;
      first_error_r <= u8v_pkg::ERR_NONE;
      too_long_r    <= 1'b0;
    end else if (in_xfer && in_data.last_byte) begin
      seq_r         <= '0;
      bytes_seen_r  <= '0;
      first_error_r <= u8v_pkg::ERR_NONE;
      too_long_r    <= 1'b0;
    end else begin
      seq_r         <= seq_nxt;
      bytes_seen_r  <= bytes_seen_nxt;
      first_error_r <= first_error_nxt;
      too_long_r    <= too_long_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer && in_data.last_byte) begin
      out_valid_r <= 1'b1;
    end else if (out_xfer) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && in_data.last_byte) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/u8v_byte_check.sv @@
`timescale 1ns / 1ps
`default_nettype none

module u8v_byte_check (
  input  wire logic          [7:0] data_byte,
  input  wire logic                permit_controls,
  input  wire logic                id_mode,
  input  wire u8v_pkg::seq_t       seq_cur,
  output u8v_pkg::seq_t            seq_nxt,
  output logic               [3:0] err
);

  logic [u8v_pkg::CP_W-1:0] cp;
  logic [u8v_pkg::CP_W-1:0] cp_min;

  assign cp = {seq_cur.acc[u8v_pkg::CP_W-7:0], data_byte[5:0]};

  always_comb begin
    case (seq_cur.seq_len)
      2'd1:    cp_min = u8v_pkg::CP_MIN_2;
      2'd2:    cp_min = u8v_pkg::CP_MIN_3;
      default: cp_min = u8v_pkg::CP_MIN_4;
    endcase
  end

  always_comb begin
    seq_nxt = seq_cur;
    err     = u8v_pkg::ERR_NONE;
    if (seq_cur.pending == 2'd0) begin
      if (!data_byte[7]) begin
        if (data_byte == 8'h00) begin
          err = u8v_pkg::ERR_CONTROL;
        end else if (!permit_controls && (data_byte < 8'h20 || data_byte == 8'h7f)) begin
          err = u8v_pkg::ERR_CONTROL;
        end else if (id_mode && (data_byte <= 8'h20 || data_byte == 8'h7f)) begin
          err = u8v_pkg::ERR_ID_BYTE;
        end
      end else if (data_byte inside {[8'hc2:8'hdf]}) begin
        seq_nxt.pending = 2'd1;
        seq_nxt.seq_len = 2'd1;
        seq_nxt.acc     = u8v_pkg::CP_W'(data_byte[4:0]);
      end else if (data_byte inside {[8'he0:8'hef]}) begin
        seq_nxt.pending = 2'd2;
        seq_nxt.seq_len = 2'd2;
        seq_nxt.acc     = u8v_pkg::CP_W'(data_byte[3:0]);
      end else if (data_byte inside {[8'hf0:8'hf4]}) begin
        seq_nxt.pending = 2'd3;
        seq_nxt.seq_len = 2'd3;
        seq_nxt.acc     = u8v_pkg::CP_W'(data_byte[2:0]);
      end else begin
        err = u8v_pkg::ERR_BAD_LEAD;
      end
    end else if (data_byte[7:6] != 2'b10) begin
      err = u8v_pkg::ERR_BAD_CONT;
    end else begin
      seq_nxt.acc     = cp;
      seq_nxt.pending = seq_cur.pending - 2'd1;
      // sequence complete: range, overlong and surrogate checks, then C1
      if (seq_cur.pending == 2'd1) begin
        if (cp < cp_min || cp > u8v_pkg::CP_MAX ||
            (cp >= u8v_pkg::CP_SURR_LO && cp <= u8v_pkg::CP_SURR_HI)) begin
          err = u8v_pkg::ERR_RANGE;
        end else if (!permit_controls && cp >= u8v_pkg::CP_MIN_2 &&
                     cp <= u8v_pkg::CP_C1_HI) begin
          err = u8v_pkg::ERR_CONTROL;
        end
      end
    end
  end

endmodule

`default_nettype wire
